// ----- src/mdec_pkg.sv -----
package mdec_pkg;

    // operation codes reported in op_kind
    localparam logic [4:0] OP_UNKNOWN = 5'd0;
    localparam logic [4:0] OP_NOP     = 5'd1;
    localparam logic [4:0] OP_BREAK   = 5'd2;
    localparam logic [4:0] OP_JR      = 5'd3;
    localparam logic [4:0] OP_ADD     = 5'd4;
    localparam logic [4:0] OP_SUB     = 5'd5;
    localparam logic [4:0] OP_SLL     = 5'd6;
    localparam logic [4:0] OP_SRL     = 5'd7;
    localparam logic [4:0] OP_SRA     = 5'd8;
    localparam logic [4:0] OP_MUL     = 5'd9;
    localparam logic [4:0] OP_J       = 5'd10;
    localparam logic [4:0] OP_LW      = 5'd11;
    localparam logic [4:0] OP_SW      = 5'd12;
    localparam logic [4:0] OP_BEQ     = 5'd13;
    localparam logic [4:0] OP_BLTZ    = 5'd14;
    localparam logic [4:0] OP_BGTZ    = 5'd15;
    localparam logic [4:0] OP_ADDI    = 5'd16;
    localparam logic [4:0] OP_SUBI    = 5'd17;
    localparam logic [4:0] OP_MULI    = 5'd18;
    localparam logic [4:0] OP_ANDI    = 5'd19;
    localparam logic [4:0] OP_NORI    = 5'd20;
    localparam logic [4:0] OP_SLTI    = 5'd21;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL  = 6'b000000;
    localparam logic [5:0] OPC_REGIMM   = 6'b000001;
    localparam logic [5:0] OPC_J        = 6'b000010;
    localparam logic [5:0] OPC_BEQ      = 6'b000100;
    localparam logic [5:0] OPC_BGTZ     = 6'b000111;
    localparam logic [5:0] OPC_SPECIAL2 = 6'b011100;
    localparam logic [5:0] OPC_LW       = 6'b100011;
    localparam logic [5:0] OPC_SW       = 6'b101011;
    localparam logic [5:0] OPC_ADDI     = 6'b110000;
    localparam logic [5:0] OPC_SUBI     = 6'b110001;
    localparam logic [5:0] OPC_MULI     = 6'b100001;
    localparam logic [5:0] OPC_ANDI     = 6'b110010;
    localparam logic [5:0] OPC_NORI     = 6'b110011;
    localparam logic [5:0] OPC_SLTI     = 6'b110101;

    // function codes and fixed low fields
    localparam logic [5:0]  FN_SLL   = 6'b000000;
    localparam logic [5:0]  FN_SRL   = 6'b000010;
    localparam logic [5:0]  FN_SRA   = 6'b000011;
    localparam logic [5:0]  FN_JR    = 6'b001000;
    localparam logic [5:0]  FN_BREAK = 6'b001101;
    localparam logic [10:0] LOW_ADD  = 11'b00000100000;
    localparam logic [10:0] LOW_SUB  = 11'b00000100010;
    localparam logic [10:0] LOW_MUL  = 11'b00000000010;

    typedef struct packed {
        logic        matched;
        logic [4:0]  op_kind;
        logic        immediate_form;
        logic [4:0]  src_reg;
        logic [4:0]  tgt_reg;
        logic [4:0]  dst_reg;
        logic [4:0]  shift_amount;
        logic [15:0] imm_value;
        logic [17:0] mem_or_branch_offset;
        logic [27:0] jump_target;
        logic        is_break;
    } decode_t;

endpackage

// ----- src/mdec_in_stage.sv -----
module mdec_in_stage
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;

    // stage frees up when empty or when its request moves on
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- src/mdec_decode.sv -----
module mdec_decode
(
    input  logic [31:0]     word,
    output mdec_pkg::decode_t dec
);

    logic [5:0]  opc;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [10:0] low11;
    logic [15:0] imm;
    logic [4:0]  imm_kind;

    assign opc   = word[31:26];
    assign rs    = word[25:21];
    assign rt    = word[20:16];
    assign rd    = word[15:11];
    assign sa    = word[10:6];
    assign fn    = word[5:0];
    assign low11 = word[10:0];
    assign imm   = word[15:0];

    always_comb
    begin
        case (opc)
            mdec_pkg::OPC_ADDI: imm_kind = mdec_pkg::OP_ADDI;
            mdec_pkg::OPC_SUBI: imm_kind = mdec_pkg::OP_SUBI;
            mdec_pkg::OPC_MULI: imm_kind = mdec_pkg::OP_MULI;
            mdec_pkg::OPC_ANDI: imm_kind = mdec_pkg::OP_ANDI;
            mdec_pkg::OPC_NORI: imm_kind = mdec_pkg::OP_NORI;
            mdec_pkg::OPC_SLTI: imm_kind = mdec_pkg::OP_SLTI;
            default:            imm_kind = mdec_pkg::OP_UNKNOWN;
        endcase
    end

    // first match wins, unused fields stay zero
    always_comb
    begin
        dec = '0;
        if (imm_kind != mdec_pkg::OP_UNKNOWN)
        begin
            dec.matched        = 1'b1;
            dec.op_kind        = imm_kind;
            dec.immediate_form = 1'b1;
            dec.src_reg        = rs;
            dec.tgt_reg        = rt;
            dec.imm_value      = imm;
        end
        else if (word == 32'd0)
        begin
            dec.matched = 1'b1;
            dec.op_kind = mdec_pkg::OP_NOP;
        end
        else if (opc == mdec_pkg::OPC_SPECIAL && fn == mdec_pkg::FN_BREAK)
        begin
            dec.matched  = 1'b1;
            dec.op_kind  = mdec_pkg::OP_BREAK;
            dec.is_break = 1'b1;
        end
        else if (opc == mdec_pkg::OPC_SPECIAL && word[20:11] == 10'd0
                 && fn == mdec_pkg::FN_JR)
        begin
            dec.matched = 1'b1;
            dec.op_kind = mdec_pkg::OP_JR;
            dec.src_reg = rs;
        end
        else if (opc == mdec_pkg::OPC_SPECIAL
                 && (low11 == mdec_pkg::LOW_ADD || low11 == mdec_pkg::LOW_SUB))
        begin
            dec.matched = 1'b1;
            dec.op_kind = (low11 == mdec_pkg::LOW_ADD) ? mdec_pkg::OP_ADD
                                                       : mdec_pkg::OP_SUB;
            dec.src_reg = rs;
            dec.tgt_reg = rt;
            dec.dst_reg = rd;
        end
        else if (opc == mdec_pkg::OPC_SPECIAL && rs == 5'd0
                 && (fn == mdec_pkg::FN_SLL || fn == mdec_pkg::FN_SRL
                     || fn == mdec_pkg::FN_SRA))
        begin
            dec.matched      = 1'b1;
            dec.op_kind      = (fn == mdec_pkg::FN_SLL) ? mdec_pkg::OP_SLL
                             : (fn == mdec_pkg::FN_SRL) ? mdec_pkg::OP_SRL
                                                        : mdec_pkg::OP_SRA;
            dec.tgt_reg      = rt;
            dec.dst_reg      = rd;
            dec.shift_amount = sa;
        end
        else if (opc == mdec_pkg::OPC_J)
        begin
            dec.matched     = 1'b1;
            dec.op_kind     = mdec_pkg::OP_J;
            dec.jump_target = {word[25:0], 2'b00};
        end
        else if (opc == mdec_pkg::OPC_LW || opc == mdec_pkg::OPC_SW)
        begin
            dec.matched              = 1'b1;
            dec.op_kind              = (opc == mdec_pkg::OPC_LW) ? mdec_pkg::OP_LW
                                                                 : mdec_pkg::OP_SW;
            dec.src_reg              = rs;
            dec.tgt_reg              = rt;
            dec.mem_or_branch_offset = {2'b00, imm};
        end
        else if (opc == mdec_pkg::OPC_BEQ)
        begin
            dec.matched              = 1'b1;
            dec.op_kind              = mdec_pkg::OP_BEQ;
            dec.src_reg              = rs;
            dec.tgt_reg              = rt;
            dec.mem_or_branch_offset = {imm, 2'b00};
        end
        else if (rt == 5'd0
                 && (opc == mdec_pkg::OPC_REGIMM || opc == mdec_pkg::OPC_BGTZ))
        begin
            dec.matched              = 1'b1;
            dec.op_kind              = (opc == mdec_pkg::OPC_REGIMM) ? mdec_pkg::OP_BLTZ
                                                                     : mdec_pkg::OP_BGTZ;
            dec.src_reg              = rs;
            dec.mem_or_branch_offset = {imm, 2'b00};
        end
        else if (opc == mdec_pkg::OPC_SPECIAL2 && low11 == mdec_pkg::LOW_MUL)
        begin
            dec.matched = 1'b1;
            dec.op_kind = mdec_pkg::OP_MUL;
            dec.src_reg = rs;
            dec.tgt_reg = rt;
            dec.dst_reg = rd;
        end
    end

endmodule

// ----- src/mdec_out_stage.sv -----
module mdec_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mdec_pkg::decode_t in_dec,
    output logic              out_valid,
    input  logic              out_ready,
    output mdec_pkg::decode_t out_dec
);

    logic              valid_reg;
    logic              valid_next;
    mdec_pkg::decode_t dec_reg;

    // result waits here while the output side stalls, and then the input side stalls too
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dec_reg <= in_dec;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

// ----- src/mips_subset_instruction_decoder.sv -----
// path: an accepted request passes the word register, then the result register, to the master side
// throughput: one instruction word per cycle unless m_axis_tready stalls it,
// set by the single decode stage between the word and result registers
// reset: rst_n is asynchronous, active low, and empties both stages; no
// request is held or produced during reset
module mips_subset_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // instr_word

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // from bit 0: src_reg, tgt_reg, dst_reg, shift_amount, imm_value,
    // mem_or_branch_offset, jump_target, zero pad
    output logic [87:0] m_axis_tdata,
    // from bit 0: matched, op_kind, immediate_form, is_break
    output logic [7:0]  m_axis_tuser
);

    // word register -> decode logic
    logic              word_valid;
    logic              word_ready;
    logic [31:0]       word;

    // decode logic -> result register
    mdec_pkg::decode_t dec;
    mdec_pkg::decode_t res;

    // input register holds one word; it drains as soon as the result
    // register can take the decoded request
    mdec_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata),
        .out_valid (word_valid),
        .out_ready (word_ready),
        .out_word  (word)
    );

    // priority decode: immediate ops, special, jump/load/store/branch, special2
    mdec_decode u_decode
    (
        .word (word),
        .dec  (dec)
    );

    // result register toward the master side
    mdec_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (word_valid),
        .in_ready  (word_ready),
        .in_dec    (dec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_dec   (res)
    );

    // pack the result fields onto the bus
    assign m_axis_tdata = {6'd0,
                           res.jump_target,
                           res.mem_or_branch_offset,
                           res.imm_value,
                           res.shift_amount,
                           res.dst_reg,
                           res.tgt_reg,
                           res.src_reg};

    assign m_axis_tuser = {res.is_break,
                           res.immediate_form,
                           res.op_kind,
                           res.matched};

    // an unknown word yields an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !res.matched) |-> (m_axis_tdata == 88'd0 && m_axis_tuser == 8'd0))
        else $error("unknown word with nonzero fields");

    // break flag only with the break code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.is_break) |-> (res.op_kind == mdec_pkg::OP_BREAK))
        else $error("break flag on wrong op code");

    // immediate form exactly for the category-2 codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.immediate_form == (res.op_kind >= mdec_pkg::OP_ADDI)))
        else $error("immediate form flag mismatch");

    // an accepted request always lands in the word register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> word_valid)
        else $error("accepted request lost");

endmodule
